[hdl/scs_pkg.sv]
package scs_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);

   localparam logic [15:0] MAX_SKIP_RESET = 16'd256;

   // stream bytes that steer the parser
   localparam logic [7:0] BYTE_START   = 8'hF0;
   localparam logic [7:0] BYTE_STATUS  = 8'h80;
   localparam logic [7:0] BYTE_A_HDR0  = 8'h00;
   localparam logic [7:0] BYTE_A_HDR1  = 8'h32;
   localparam logic [7:0] BYTE_A_HDR2  = 8'h45;
   localparam logic [7:0] BYTE_B_HDR0  = 8'h22;
   localparam logic [7:0] BYTE_B_HDR1  = 8'h24;
   localparam logic [7:0] BYTE_B_HDR2  = 8'h35;
   localparam logic [7:0] BYTE_B_UPGR  = 8'h7F;

   typedef logic [1:0]       command_type;
   typedef logic [IDX_W-1:0] index_type;

   localparam command_type CMD_NONE    = 2'd0;
   localparam command_type CMD_VERIFY  = 2'd1;
   localparam command_type CMD_UPGRADE = 2'd2;

   localparam logic REQ_FEED = 1'b0;
   localparam logic REQ_POLL = 1'b1;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_H0   = 9'b000000010,
      ST_A1   = 9'b000000100,
      ST_A2   = 9'b000001000,
      ST_ACMD = 9'b000010000,
      ST_PAY  = 9'b000100000,
      ST_B1   = 9'b001000000,
      ST_B2   = 9'b010000000,
      ST_BCMD = 9'b100000000
   } parser_state_type;

   function automatic index_type ring_next(input index_type idx);
      if (idx == index_type'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return idx + index_type'(1);
   endfunction

endpackage

[hdl/sysex_command_sniffer.sv]
// System-exclusive command sniffer.
// req channel: req_type 0 feeds one stream byte (req_data_byte), req_type 1
// polls the command queue. Feeds give no response; each poll gives exactly
// one rsp transfer carrying rsp_command (0 none pending, 1 verify, 2 upgrade).
// csr channel: writes max_skip, the payload byte count at which an oversized
// frame is dropped; csr_ready is always high, write only while idle.
// Path: a poll accepted into the input register loads the result register
// when it advances, and its rsp transfer comes from the result register
// (input register, then result register). Throughput: one item per cycle,
// fed or polled, with back-to-back polls as long as rsp_ready stays high.
// Stall: when rsp_ready is low the result register holds; the input register
// still takes one more item and keeps moving feeds through, and req_ready
// drops only while a poll waits behind an untaken result.
// Reset: parser to idle, queue emptied, max_skip back to 256, both pipeline
// registers empty. Queue holds QUEUE_DEPTH-1 codes; a push into a full
// queue drops the oldest code.
module sysex_command_sniffer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  logic [7:0]          req_data_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output scs_pkg::command_type rsp_command,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [15:0]         csr_max_skip
);
   import scs_pkg::*;

   logic             in_valid_ff;
   logic             in_type_ff;
   logic [7:0]       in_byte_ff;
   logic             rsp_valid_ff;
   command_type      rsp_command_ff;
   logic [15:0]      max_skip_ff;
   parser_state_type state_ff, state_in;
   logic [15:0]      count_ff, count_in;
   command_type      ring_ff [QUEUE_DEPTH];
   index_type        wr_ff, wr_in;
   index_type        rd_ff, rd_in;

   logic        advance;
   logic        is_poll;
   logic        push;
   command_type push_code;
   command_type poll_code;
   logic        is_status;
   logic [15:0] count_inc;

   assign is_poll   = (in_type_ff == REQ_POLL);
   assign advance   = in_valid_ff && (!is_poll || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_command = rsp_command_ff;

   assign is_status = (in_byte_ff >= BYTE_STATUS);
   assign count_inc = count_ff + 16'd1;

   // parser
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      push      = 1'b0;
      push_code = CMD_NONE;
      if (in_byte_ff == BYTE_START) begin
         state_in = ST_H0;
      end else begin
         unique case (state_ff)
            ST_H0: begin
               if (in_byte_ff == BYTE_A_HDR0) state_in = ST_A1;
               else if (in_byte_ff == BYTE_B_HDR0) state_in = ST_B1;
               else state_in = ST_IDLE;
            end
            ST_A1: state_in = (in_byte_ff == BYTE_A_HDR1) ? ST_A2 : ST_IDLE;
            ST_A2: state_in = (in_byte_ff == BYTE_A_HDR2) ? ST_ACMD : ST_IDLE;
            ST_B1: state_in = (in_byte_ff == BYTE_B_HDR1) ? ST_B2 : ST_IDLE;
            ST_B2: state_in = (in_byte_ff == BYTE_B_HDR2) ? ST_BCMD : ST_IDLE;
            ST_ACMD: begin
               if (is_status) begin
                  state_in = ST_IDLE;
               end else begin
                  if (in_byte_ff == 8'(CMD_VERIFY) || in_byte_ff == 8'(CMD_UPGRADE)) begin
                     push      = 1'b1;
                     push_code = in_byte_ff[1:0];
                  end
                  state_in = ST_PAY;
                  count_in = '0;
               end
            end
            ST_BCMD: begin
               if (is_status) begin
                  state_in = ST_IDLE;
               end else begin
                  if (in_byte_ff == BYTE_B_UPGR) begin
                     push      = 1'b1;
                     push_code = CMD_UPGRADE;
                  end
                  state_in = ST_PAY;
                  count_in = '0;
               end
            end
            ST_PAY: begin
               if (is_status) begin
                  state_in = ST_IDLE;
               end else begin
                  count_in = count_inc;
                  if (count_inc >= max_skip_ff) state_in = ST_IDLE;
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   // ring pointers: a push into a full ring pushes the read side along
   always_comb begin
      wr_in     = wr_ff;
      rd_in     = rd_ff;
      poll_code = CMD_NONE;
      if (is_poll) begin
         if (wr_ff != rd_ff) begin
            poll_code = ring_ff[rd_ff];
            rd_in     = ring_next(rd_ff);
         end
      end else if (push) begin
         wr_in = ring_next(wr_ff);
         if (ring_next(wr_ff) == rd_ff) rd_in = ring_next(rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_skip_ff  <= MAX_SKIP_RESET;
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         wr_ff        <= '0;
         rd_ff        <= '0;
         for (int i = 0; i < QUEUE_DEPTH; i++) ring_ff[i] <= CMD_NONE;
      end else begin
         if (csr_valid && csr_ready) max_skip_ff <= csr_max_skip;
         if (req_ready) in_valid_ff <= req_valid;
         if (advance && is_poll) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            wr_ff <= wr_in;
            rd_ff <= rd_in;
            if (!is_poll) begin
               state_ff <= state_in;
               count_ff <= count_in;
               if (push) ring_ff[wr_ff] <= push_code;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_type_ff <= req_type;
         in_byte_ff <= req_data_byte;
      end
      if (advance && is_poll) rsp_command_ff <= poll_code;
   end

endmodule

[hdl/scs_checker.sv]
module scs_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 req_type,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input scs_pkg::command_type rsp_command
);
   import scs_pkg::*;

   // held result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_command))
      else $error("rsp changed while stalled");

   // a fresh response is checked against an earlier poll transfer
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_type == REQ_POLL, 2))
      else $error("response without matching poll");

   // input backpressure only behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req stalled without output stall");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind sysex_command_sniffer scs_checker u_scs_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import scs_pkg::*;

   localparam int CLK_HALF       = 4;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_CYCLES   = 4;

   typedef logic [7:0] byte_list_type [$];

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_ready;
   logic              req_type      = REQ_FEED;
   logic [7:0]        req_data_byte = 8'h00;
   logic              rsp_valid;
   logic              rsp_ready     = 1'b0;
   command_type       rsp_command;
   logic              csr_valid     = 1'b0;
   logic              csr_ready;
   logic [15:0]       csr_max_skip  = MAX_SKIP_RESET;

   // sniffer mirror
   parser_state_type  pstate;
   logic [15:0]       payload_cnt;
   logic [15:0]       skip_limit;
   command_type       code_ring [QUEUE_DEPTH];
   index_type         wr_idx;
   index_type         rd_idx;
   command_type       pending_codes [$];

   int                error_count   = 0;
   int                items_sent    = 0;
   int                send_idle_pct = 0;
   int                rsp_stall_pct = 0;
   int                hold_trigger  = 0;
   int                hold_seen     = 0;
   int                hold_left     = 0;
   int                quiet_cycles  = 0;

   sysex_command_sniffer u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_command   (rsp_command),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_max_skip  (csr_max_skip)
   );

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   function automatic index_type ring_step(input index_type i);
      return index_type'((int'(i) + 1) % QUEUE_DEPTH);
   endfunction

   task automatic push_code(input command_type code);
      index_type n;
      n = ring_step(wr_idx);
      // full ring loses its oldest code
      if (n == rd_idx) begin
         rd_idx = ring_step(rd_idx);
      end
      code_ring[wr_idx] = code;
      wr_idx = n;
   endtask

   task automatic track_request(input logic kind, input logic [7:0] b);
      command_type code;
      if (kind == REQ_POLL) begin
         code = CMD_NONE;
         if (wr_idx != rd_idx) begin
            code = code_ring[rd_idx];
            rd_idx = ring_step(rd_idx);
         end
         pending_codes.push_back(code);
      end else if (b == BYTE_START) begin
         pstate = ST_H0;
      end else begin
         case (pstate)
            ST_H0: begin
               if (b == BYTE_A_HDR0) pstate = ST_A1;
               else if (b == BYTE_B_HDR0) pstate = ST_B1;
               else pstate = ST_IDLE;
            end
            ST_A1: pstate = (b == BYTE_A_HDR1) ? ST_A2 : ST_IDLE;
            ST_A2: pstate = (b == BYTE_A_HDR2) ? ST_ACMD : ST_IDLE;
            ST_B1: pstate = (b == BYTE_B_HDR1) ? ST_B2 : ST_IDLE;
            ST_B2: pstate = (b == BYTE_B_HDR2) ? ST_BCMD : ST_IDLE;
            ST_ACMD: begin
               if (b >= BYTE_STATUS) begin
                  pstate = ST_IDLE;
               end else begin
                  if (b == 8'(CMD_VERIFY) || b == 8'(CMD_UPGRADE)) push_code(b[1:0]);
                  pstate = ST_PAY;
                  payload_cnt = '0;
               end
            end
            ST_BCMD: begin
               if (b >= BYTE_STATUS) begin
                  pstate = ST_IDLE;
               end else begin
                  if (b == BYTE_B_UPGR) push_code(CMD_UPGRADE);
                  pstate = ST_PAY;
                  payload_cnt = '0;
               end
            end
            ST_PAY: begin
               if (b >= BYTE_STATUS) begin
                  pstate = ST_IDLE;
               end else begin
                  payload_cnt = payload_cnt + 16'd1;
                  if (payload_cnt >= skip_limit) pstate = ST_IDLE;
               end
            end
            default: pstate = ST_IDLE;
         endcase
      end
   endtask

   task automatic report_mismatch(input string what, input command_type got,
                                  input command_type want);
      $display("mismatch at %0t: %s, got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // result checking and receiver stalls
   always @(posedge clock) begin
      command_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_codes.size() == 0) begin
            report_mismatch("result with nothing pending", rsp_command, CMD_NONE);
         end else begin
            want = pending_codes.pop_front();
            if (rsp_command !== want) report_mismatch("rsp_command", rsp_command, want);
         end
      end
      if (hold_trigger != hold_seen) begin
         hold_seen = hold_trigger;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_item(input logic kind, input logic [7:0] b);
      int gap;
      gap = 0;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct && gap < 200) begin
         gap++;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_data_byte <= b;
      do @(posedge clock); while (!req_ready);
      track_request(kind, b);
      items_sent++;
   endtask

   task automatic send_feeds(input byte_list_type list);
      foreach (list[i]) send_item(REQ_FEED, list[i]);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_codes.size() != 0) @(posedge clock);
      // a feed may still sit in the pipeline
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_skip(input logic [15:0] value);
      drain_results();
      csr_valid    <= 1'b1;
      csr_max_skip <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      skip_limit = value;
   endtask

   // mostly the right header byte, now and then a wrong one
   function automatic logic [7:0] header_byte(input logic [7:0] good);
      return ($urandom_range(11) == 0) ? 8'($urandom) : good;
   endfunction

   task automatic send_random_burst();
      int unsigned pick, len, lim;
      logic [7:0]  cmd;
      pick = $urandom_range(99);
      if (pick < 30) begin
         repeat ($urandom_range(1, 3)) send_item(REQ_POLL, 8'($urandom));
      end else if (pick < 42) begin
         send_item(REQ_FEED, 8'($urandom));
      end else begin
         send_item(REQ_FEED, BYTE_START);
         if ($urandom_range(1) == 0) begin
            send_item(REQ_FEED, header_byte(BYTE_A_HDR0));
            send_item(REQ_FEED, header_byte(BYTE_A_HDR1));
            send_item(REQ_FEED, header_byte(BYTE_A_HDR2));
            case ($urandom_range(3))
               0: cmd = 8'(CMD_VERIFY);
               1: cmd = 8'(CMD_UPGRADE);
               2: cmd = 8'($urandom_range(8'h7F));
               default: cmd = 8'($urandom_range(8'hFF, 8'h80));
            endcase
         end else begin
            send_item(REQ_FEED, header_byte(BYTE_B_HDR0));
            send_item(REQ_FEED, header_byte(BYTE_B_HDR1));
            send_item(REQ_FEED, header_byte(BYTE_B_HDR2));
            case ($urandom_range(3))
               0, 1: cmd = BYTE_B_UPGR;
               2: cmd = 8'($urandom_range(8'h7F));
               default: cmd = 8'($urandom_range(8'hFF, 8'h80));
            endcase
         end
         send_item(REQ_FEED, cmd);
         lim = (skip_limit < 12) ? int'(skip_limit) + 1 : 12;
         if ($urandom_range(15) == 0) begin
            lim = (skip_limit < 298) ? int'(skip_limit) + 2 : 300;
         end
         len = $urandom_range(lim);
         repeat (len) send_item(REQ_FEED, 8'($urandom_range(8'h7F)));
         case ($urandom_range(5))
            0, 1, 2: send_item(REQ_FEED, 8'hF7);
            3: send_item(REQ_FEED, 8'($urandom_range(8'hFF, 8'h80)));
            4: send_item(REQ_FEED, BYTE_START);
            default: ;
         endcase
      end
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_item(REQ_POLL, 8'hFF);
      send_item(REQ_FEED, 8'h55);
      send_feeds('{BYTE_START, BYTE_A_HDR0, BYTE_A_HDR1, BYTE_A_HDR2, 8'h01});
      send_feeds('{BYTE_START, BYTE_B_HDR0, BYTE_B_HDR1, BYTE_B_HDR2, BYTE_B_UPGR});
      send_feeds('{BYTE_START, BYTE_A_HDR0, BYTE_A_HDR1, BYTE_A_HDR2, 8'h02});
      // ring now full, this one pushes out the verify
      send_feeds('{BYTE_START, BYTE_B_HDR0, BYTE_B_HDR1, BYTE_B_HDR2, BYTE_B_UPGR});
      repeat (4) send_item(REQ_POLL, 8'h00);
   endtask

   task automatic test_random(input int count, input int idle_pct, input int stall_pct);
      int start;
      start         = items_sent;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      while (items_sent - start < count) send_random_burst();
   endtask

   task automatic test_long_stall();
      int k;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_trigger++;
      for (k = 0; k < 60; k++) begin
         if (k % 3 == 0) send_random_burst();
         else send_item(REQ_POLL, 8'($urandom));
      end
   endtask

   task automatic test_drain_pause();
      int k;
      send_idle_pct = 17;
      rsp_stall_pct = 17;
      for (k = 0; k < 8; k++) begin
         repeat ($urandom_range(1, 6)) send_random_burst();
         drain_results();
      end
   endtask

   initial begin
      pstate      = ST_IDLE;
      payload_cnt = '0;
      skip_limit  = MAX_SKIP_RESET;
      wr_idx      = '0;
      rd_idx      = '0;
      foreach (code_ring[i]) code_ring[i] = CMD_NONE;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(150, 0, 0);
      write_max_skip(16'd1);
      test_random(300, 86, 0);
      write_max_skip(16'd3);
      test_random(300, 0, 86);
      write_max_skip(16'hFFFF);
      test_random(300, 17, 17);
      write_max_skip(16'd2);
      test_long_stall();
      test_drain_pause();
      write_max_skip(16'd5);
      test_random(300, 0, 0);

      drain_results();
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/scs_pkg.sv
hdl/sysex_command_sniffer.sv
hdl/scs_checker.sv
tb/tb_top.sv
